FILE: sv/fcr_pkg.sv
// Package: shared types, constants and the CRC-16/CCITT byte step for the frame receiver.
package fcr_pkg;

    localparam int QueueDepthDef = 8;
    localparam int MaxPayloadDef = 32;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;

    localparam logic [7:0] FirstMagicRst  = 8'hAA;
    localparam logic [7:0] SecondMagicRst = 8'h55;
    localparam logic [7:0] VersionRst     = 8'h01;

    localparam logic [7:0] CharUpperG = 8'h47;
    localparam logic [7:0] CharLowerG = 8'h67;
    localparam logic [7:0] CharUpperS = 8'h53;
    localparam logic [7:0] CharLowerS = 8'h73;

    localparam int CfgAddrW = 4;
    localparam logic [1:0] RegFirstMagic  = 2'd0;
    localparam logic [1:0] RegSecondMagic = 2'd1;
    localparam logic [1:0] RegVersion     = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        FS_NONE     = 3'd0,
        FS_ACCEPTED = 3'd1,
        FS_FULL     = 3'd2,
        FS_BAD      = 3'd3,
        FS_TOO_LONG = 3'd4
    } frame_status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MAGIC,
        OP_VERSION,
        OP_COMMAND,
        OP_SEQUENCE,
        OP_LENGTH,
        OP_PAYLOAD,
        OP_CRC_LO
    } dp_op_t;

    typedef struct packed {
        dp_op_t        op;
        logic          push;
        logic          out_load;
        kind_t         out_kind;
        frame_status_t out_status;
        logic          dq_begin;
        logic          dq_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic byte_first_magic;
        logic byte_second_magic;
        logic len_too_long;
        logic len_zero;
        logic payload_done;
        logic frame_ok;
        logic q_full;
        logic q_empty;
        logic dq_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/fcr_if.sv
// Interfaces: input byte/request channel and result channel.
interface fcr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, func, rx_byte, input ready);
    modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface fcr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic       capture_request;
    logic       status_request;
    logic [2:0] frame_status;
    logic [7:0] command;
    logic [7:0] sequence_res;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;

    modport source (output valid, result_kind, capture_request, status_request, frame_status,
                    command, sequence_res, payload_length, payload_byte, payload_valid, last,
                    input ready);
    modport sink   (input valid, result_kind, capture_request, status_request, frame_status,
                    command, sequence_res, payload_length, payload_byte, payload_valid, last,
                    output ready);
endinterface

FILE: sv/fcr_ram.sv
// Generic simple dual-port RAM with registered read.
module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/fcr_regs.sv
// Configuration registers behind the APB-style port.
module fcr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcr_pkg::CfgAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [7:0]                    first_magic,
    output logic [7:0]                    second_magic,
    output logic [7:0]                    accepted_version,
    output logic [15:0]                   magic_crc
);
    import fcr_pkg::*;

    logic [7:0]  first_magic_reg;
    logic [7:0]  second_magic_reg;
    logic [7:0]  version_reg;
    logic [15:0] magic_crc_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // magic_crc holds the CRC after the first magic byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_magic_reg  <= FirstMagicRst;
            second_magic_reg <= SecondMagicRst;
            version_reg      <= VersionRst;
            magic_crc_reg    <= crc_feed(CrcInit, FirstMagicRst);
        end
        else if (wr_en)
        begin
            priority if (reg_idx == RegFirstMagic)
            begin
                first_magic_reg <= pwdata[7:0];
                magic_crc_reg   <= crc_feed(CrcInit, pwdata[7:0]);
            end
            else if (reg_idx == RegSecondMagic)
            begin
                second_magic_reg <= pwdata[7:0];
            end
            else if (reg_idx == RegVersion)
            begin
                version_reg <= pwdata[7:0];
            end
            else
            begin
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        priority if (reg_idx == RegFirstMagic)
        begin
            prdata[7:0] = first_magic_reg;
        end
        else if (reg_idx == RegSecondMagic)
        begin
            prdata[7:0] = second_magic_reg;
        end
        else if (reg_idx == RegVersion)
        begin
            prdata[7:0] = version_reg;
        end
        else
        begin
            prdata = '0;
        end
    end

    assign first_magic      = first_magic_reg;
    assign second_magic     = second_magic_reg;
    assign accepted_version = version_reg;
    assign magic_crc        = magic_crc_reg;
endmodule

FILE: sv/fcr_datapath.sv
// Datapath: frame fields, CRC, queue pointers, header/payload RAMs and result register.
module fcr_datapath #(
    parameter int QUEUE_DEPTH = fcr_pkg::QueueDepthDef,
    parameter int MAX_PAYLOAD = fcr_pkg::MaxPayloadDef
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             first_magic,
    input  logic [7:0]             second_magic,
    input  logic [7:0]             accepted_version,
    input  logic [15:0]            magic_crc,
    input  fcr_pkg::ctrl_cmd_t     cmd,
    output fcr_pkg::dp_status_t    st,
    fcr_out_if.source              res_out
);
    import fcr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = $clog2(QUEUE_DEPTH * MAX_PAYLOAD);
    localparam int HW = 16 + CW;

    logic [7:0]    frame_version_reg;
    logic [7:0]    frame_command_reg;
    logic [7:0]    frame_sequence_reg;
    logic [CW-1:0] frame_length_reg;
    logic [CW-1:0] payload_count_reg;
    logic [15:0]   crc_reg;
    logic [7:0]    crc_lo_reg;
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] k_reg;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic          out_cap_reg;
    logic          out_stat_reg;
    logic [2:0]    out_fs_reg;
    logic [7:0]    out_cmd_reg;
    logic [7:0]    out_seq_reg;
    logic [5:0]    out_len_reg;
    logic [7:0]    out_byte_reg;
    logic          out_pv_reg;
    logic          out_last_reg;

    logic [15:0]   crc_step;
    logic [PW-1:0] wptr_inc;
    logic [PW-1:0] rptr_inc;
    logic [HW-1:0] hdr_wdata;
    logic [HW-1:0] hdr_rdata;
    logic [7:0]    pay_rdata;
    logic [AW-1:0] pay_waddr;
    logic [AW-1:0] pay_raddr;
    logic [CW-1:0] hd_len;
    logic [CW-1:0] hd_cnt;
    logic [6:0]    hd_len7;
    logic          len_nz;

    assign crc_step = crc_feed(crc_reg, rx_byte);
    assign wptr_inc = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;

    assign hdr_wdata = {frame_command_reg, frame_sequence_reg, frame_length_reg};
    assign hd_len    = hdr_rdata[CW-1:0];
    assign len_nz    = (hd_len != '0);
    assign hd_cnt    = len_nz ? hd_len : CW'(1);
    assign hd_len7   = 7'(hd_len);

    assign pay_waddr = AW'(AW'(wptr_reg) * AW'(MAX_PAYLOAD)) + AW'(payload_count_reg);
    assign pay_raddr = AW'(AW'(rptr_reg) * AW'(MAX_PAYLOAD)) + AW'(k_reg);

    fcr_ram #(.WIDTH(HW), .DEPTH(QUEUE_DEPTH)) u_hdr_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (wptr_reg),
        .wdata (hdr_wdata),
        .raddr (rptr_reg),
        .rdata (hdr_rdata)
    );

    fcr_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH * MAX_PAYLOAD)) u_pay_ram (
        .clk   (clk),
        .we    (cmd.op == OP_PAYLOAD),
        .waddr (pay_waddr),
        .wdata (rx_byte),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    always_comb
    begin
        st.byte_first_magic  = (rx_byte == first_magic);
        st.byte_second_magic = (rx_byte == second_magic);
        st.len_too_long      = ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));
        st.len_zero          = (rx_byte == 8'd0);
        st.payload_done      = (({1'b0, payload_count_reg} + 1'b1) >= {1'b0, frame_length_reg});
        st.frame_ok          = (frame_version_reg == accepted_version)
                               && ({rx_byte, crc_lo_reg} == crc_reg);
        st.q_full            = (wptr_inc == rptr_reg);
        st.q_empty           = (wptr_reg == rptr_reg);
        st.dq_last           = (({1'b0, k_reg} + 1'b1) >= {1'b0, hd_cnt});
        st.out_free          = !out_valid_reg || res_out.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                wptr_reg <= wptr_inc;
            end
            if (cmd.dq_emit && st.dq_last)
            begin
                rptr_reg <= rptr_inc;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_MAGIC:    crc_reg <= crc_feed(magic_crc, rx_byte);
            OP_VERSION:
            begin
                frame_version_reg <= rx_byte;
                crc_reg           <= crc_step;
            end
            OP_COMMAND:
            begin
                frame_command_reg <= rx_byte;
                crc_reg           <= crc_step;
            end
            OP_SEQUENCE:
            begin
                frame_sequence_reg <= rx_byte;
                crc_reg            <= crc_step;
            end
            OP_LENGTH:
            begin
                frame_length_reg  <= CW'(rx_byte);
                payload_count_reg <= '0;
                crc_reg           <= crc_step;
            end
            OP_PAYLOAD:
            begin
                payload_count_reg <= payload_count_reg + 1'b1;
                crc_reg           <= crc_step;
            end
            OP_CRC_LO:   crc_lo_reg <= rx_byte;
            default:
            begin
            end
        endcase

        if (cmd.dq_begin)
        begin
            k_reg <= '0;
        end
        else if (cmd.dq_emit)
        begin
            k_reg <= k_reg + 1'b1;
        end

        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_cap_reg  <= 1'b0;
            out_stat_reg <= 1'b0;
            out_fs_reg   <= cmd.out_status;
            out_cmd_reg  <= '0;
            out_seq_reg  <= '0;
            out_len_reg  <= '0;
            out_byte_reg <= '0;
            out_pv_reg   <= 1'b0;
            out_last_reg <= 1'b1;
            unique case (cmd.out_kind)
                KIND_BYTE:
                begin
                    out_cap_reg  <= (rx_byte == CharUpperG) || (rx_byte == CharLowerG);
                    out_stat_reg <= (rx_byte == CharUpperS) || (rx_byte == CharLowerS);
                end
                KIND_FRAME:
                begin
                    out_cmd_reg  <= hdr_rdata[HW-1 -: 8];
                    out_seq_reg  <= hdr_rdata[HW-9 -: 8];
                    out_len_reg  <= hd_len7[5:0];
                    out_byte_reg <= len_nz ? pay_rdata : 8'd0;
                    out_pv_reg   <= len_nz;
                    out_last_reg <= st.dq_last;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.result_kind     = out_kind_reg;
    assign res_out.capture_request = out_cap_reg;
    assign res_out.status_request  = out_stat_reg;
    assign res_out.frame_status    = out_fs_reg;
    assign res_out.command         = out_cmd_reg;
    assign res_out.sequence_res    = out_seq_reg;
    assign res_out.payload_length  = out_len_reg;
    assign res_out.payload_byte    = out_byte_reg;
    assign res_out.payload_valid   = out_pv_reg;
    assign res_out.last            = out_last_reg;

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !st.q_full) else $error("push into full queue");
    a_emit_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dq_emit |-> (rptr_reg != wptr_reg)) else $error("dequeue from empty queue");
    a_push_moves_wptr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (wptr_reg != $past(wptr_reg))) else $error("write pointer stuck");
endmodule

FILE: sv/fcr_ctrl.sv
// Controller: frame parser state machine and dequeue sequencer.
module fcr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 func,
    output logic                 in_ready,
    input  fcr_pkg::dp_status_t  st,
    output fcr_pkg::ctrl_cmd_t   cmd
);
    import fcr_pkg::*;

    typedef enum logic [3:0] {
        PS_MAGIC0, PS_MAGIC1, PS_VERSION, PS_COMMAND, PS_SEQUENCE,
        PS_LENGTH, PS_PAYLOAD, PS_CRC_LO, PS_CRC_HI
    } parse_state_t;

    typedef enum logic [1:0] {
        M_IDLE, M_FETCH, M_EMIT
    } mode_t;

    parse_state_t parse_state_reg, parse_state_next;
    mode_t        mode_reg, mode_next;
    logic         accept;

    assign in_ready = (mode_reg == M_IDLE) && st.out_free;
    assign accept   = in_ready && in_valid;

    always_comb
    begin
        cmd              = '0;
        parse_state_next = parse_state_reg;
        mode_next        = mode_reg;
        unique case (mode_reg)
            M_IDLE:
            begin
                if (accept && !func)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_BYTE;
                    unique case (parse_state_reg)
                        PS_MAGIC0:
                        begin
                            if (st.byte_first_magic)
                            begin
                                parse_state_next = PS_MAGIC1;
                            end
                        end
                        PS_MAGIC1:
                        begin
                            priority if (st.byte_second_magic)
                            begin
                                cmd.op           = OP_MAGIC;
                                parse_state_next = PS_VERSION;
                            end
                            else if (!st.byte_first_magic)
                            begin
                                parse_state_next = PS_MAGIC0;
                            end
                            else
                            begin
                            end
                        end
                        PS_VERSION:
                        begin
                            cmd.op           = OP_VERSION;
                            parse_state_next = PS_COMMAND;
                        end
                        PS_COMMAND:
                        begin
                            cmd.op           = OP_COMMAND;
                            parse_state_next = PS_SEQUENCE;
                        end
                        PS_SEQUENCE:
                        begin
                            cmd.op           = OP_SEQUENCE;
                            parse_state_next = PS_LENGTH;
                        end
                        PS_LENGTH:
                        begin
                            cmd.op = OP_LENGTH;
                            priority if (st.len_too_long)
                            begin
                                cmd.out_status   = FS_TOO_LONG;
                                parse_state_next = PS_MAGIC0;
                            end
                            else if (st.len_zero)
                            begin
                                parse_state_next = PS_CRC_LO;
                            end
                            else
                            begin
                                parse_state_next = PS_PAYLOAD;
                            end
                        end
                        PS_PAYLOAD:
                        begin
                            cmd.op = OP_PAYLOAD;
                            if (st.payload_done)
                            begin
                                parse_state_next = PS_CRC_LO;
                            end
                        end
                        PS_CRC_LO:
                        begin
                            cmd.op           = OP_CRC_LO;
                            parse_state_next = PS_CRC_HI;
                        end
                        PS_CRC_HI:
                        begin
                            priority if (!st.frame_ok)
                            begin
                                cmd.out_status = FS_BAD;
                            end
                            else if (st.q_full)
                            begin
                                cmd.out_status = FS_FULL;
                            end
                            else
                            begin
                                cmd.push       = 1'b1;
                                cmd.out_status = FS_ACCEPTED;
                            end
                            parse_state_next = PS_MAGIC0;
                        end
                        default: parse_state_next = PS_MAGIC0;
                    endcase
                end
                else if (accept)
                begin
                    if (st.q_empty)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_EMPTY;
                    end
                    else
                    begin
                        cmd.dq_begin = 1'b1;
                        mode_next    = M_FETCH;
                    end
                end
            end
            M_FETCH: mode_next = M_EMIT;
            M_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_FRAME;
                    cmd.dq_emit  = 1'b1;
                    mode_next    = st.dq_last ? M_IDLE : M_FETCH;
                end
            end
            default: mode_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg <= PS_MAGIC0;
            mode_reg        <= M_IDLE;
        end
        else
        begin
            parse_state_reg <= parse_state_next;
            mode_reg        <= mode_next;
        end
    end

    a_crc_hi_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !func && parse_state_reg == PS_CRC_HI) |=> (parse_state_reg == PS_MAGIC0))
        else $error("parser did not return after CRC");
    a_dq_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dq_begin |=> (mode_reg == M_FETCH) ##1 (mode_reg == M_EMIT))
        else $error("dequeue fetch sequence broken");
    a_push_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cmd.out_status == FS_ACCEPTED && cmd.out_load))
        else $error("push without accepted status");
endmodule

FILE: sv/framed_command_receiver_top.sv
// Top level: framed command receiver with CRC check, frame queue and dequeue.
//
//  channel  | dir | transfer
//  rx_in    | in  | func + rx_byte: one received byte or one dequeue request
//  res_out  | out | one result item (byte status, frame element or queue empty)
//  apb      | in  | write/read of first_magic, second_magic, accepted_version
//
//  The parser and CRC step take one byte per cycle while no dequeue runs and the
//  result register is free. A dequeue reads each payload byte from RAM, then loads it
//  into the free result register; an empty queue answers with one queue-empty item.
//  Reset clears parser state and queue pointers; no RAM clearing pass is needed.
//  A stalled result register blocks new input transfers until it is taken.
module framed_command_receiver_top #(
    parameter int QUEUE_DEPTH = fcr_pkg::QueueDepthDef,
    parameter int MAX_PAYLOAD = fcr_pkg::MaxPayloadDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fcr_in_if.sink                        rx_in,
    fcr_out_if.source                     res_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcr_pkg::CfgAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fcr_pkg::*;

    logic [7:0]  first_magic;
    logic [7:0]  second_magic;
    logic [7:0]  accepted_version;
    logic [15:0] magic_crc;
    ctrl_cmd_t   cmd;
    dp_status_t  st;

    fcr_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .first_magic      (first_magic),
        .second_magic     (second_magic),
        .accepted_version (accepted_version),
        .magic_crc        (magic_crc)
    );

    fcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx_in.valid),
        .func     (rx_in.func),
        .in_ready (rx_in.ready),
        .st       (st),
        .cmd      (cmd)
    );

    fcr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_byte          (rx_in.rx_byte),
        .first_magic      (first_magic),
        .second_magic     (second_magic),
        .accepted_version (accepted_version),
        .magic_crc        (magic_crc),
        .cmd              (cmd),
        .st               (st),
        .res_out          (res_out)
    );
endmodule

FILE: test/tb.sv
// Testbench for the framed command receiver: frame parsing, CRC and version checks, queue and dequeue.
module tb;
    import fcr_pkg::*;

    localparam int QDEPTH = 8;
    localparam int MAXPL = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        kind_t         kind;
        logic          cap;
        logic          stat;
        frame_status_t fs;
        logic [7:0]    cmd;
        logic [7:0]    seq;
        logic [5:0]    plen;
        logic [7:0]    pbyte;
        logic          pvalid;
        logic          last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CfgAddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    fcr_in_if rx_ch();
    fcr_out_if res_ch();

    framed_command_receiver_top dut (
        .clk(clk), .rst_n(rst_n), .rx_in(rx_ch.sink), .res_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [7:0]  m0, m1, ver;
    int          pstate;
    logic [7:0]  f_ver, f_cmd, f_seq, f_len, crc_lo;
    int          pcount;
    logic [15:0] crc_acc;
    logic [7:0]  pbuf [MAXPL];
    logic [7:0]  q_cmd [QDEPTH];
    logic [7:0]  q_seq [QDEPTH];
    int          q_len [QDEPTH];
    logic [7:0]  q_pl [QDEPTH][MAXPL];
    int          wptr, rptr;

    result_t expected_results[$];
    int n_items, n_results, n_mismatch, n_frames_ok, n_dequeued, idle_cycles;
    bit hold_off = 1'b0;
    bit timed_out = 1'b0;

    initial
    begin
        rx_ch.valid = 1'b0;
        rx_ch.func = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready = 1'b0;
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = (c << 1) ^ 16'h1021;
            else
                c = c << 1;
        end
        return c;
    endfunction

    function automatic void parser_clear();
        pstate = 0;
        f_ver = 0; f_cmd = 0; f_seq = 0; f_len = 0; pcount = 0;
        crc_acc = 16'hFFFF;
        crc_lo = 0;
    endfunction

    function automatic frame_status_t parse_byte(logic [7:0] b);
        frame_status_t st;
        logic [15:0] rxc;
        st = FS_NONE;
        case (pstate)
            0: if (b == m0) pstate = 1;
            1:
            begin
                if (b == m1)
                begin
                    crc_acc = crc_step(crc_step(16'hFFFF, m0), b);
                    pstate = 2;
                end
                else if (b != m0)
                    pstate = 0;
            end
            2: begin f_ver = b; crc_acc = crc_step(crc_acc, b); pstate = 3; end
            3: begin f_cmd = b; crc_acc = crc_step(crc_acc, b); pstate = 4; end
            4: begin f_seq = b; crc_acc = crc_step(crc_acc, b); pstate = 5; end
            5:
            begin
                f_len = b;
                pcount = 0;
                crc_acc = crc_step(crc_acc, b);
                if (b > MAXPL)
                begin
                    parser_clear();
                    st = FS_TOO_LONG;
                end
                else if (b == 0)
                    pstate = 7;
                else
                    pstate = 6;
            end
            6:
            begin
                if (pcount < MAXPL)
                    pbuf[pcount] = b;
                pcount++;
                crc_acc = crc_step(crc_acc, b);
                if (pcount >= f_len) pstate = 7;
            end
            7: begin crc_lo = b; pstate = 8; end
            default:
            begin
                rxc = {b, crc_lo};
                if (f_ver == ver && rxc == crc_acc)
                begin
                    if ((wptr + 1) % QDEPTH == rptr)
                        st = FS_FULL;
                    else
                    begin
                        q_cmd[wptr] = f_cmd;
                        q_seq[wptr] = f_seq;
                        q_len[wptr] = f_len;
                        for (int i = 0; i < f_len; i++) q_pl[wptr][i] = pbuf[i];
                        wptr = (wptr + 1) % QDEPTH;
                        st = FS_ACCEPTED;
                        n_frames_ok++;
                    end
                end
                else
                    st = FS_BAD;
                parser_clear();
            end
        endcase
        return st;
    endfunction

    function automatic void predict(logic f, logic [7:0] b);
        result_t r;
        int cnt;
        r = '0;
        r.kind = KIND_BYTE;
        r.fs = FS_NONE;
        if (!f)
        begin
            r.cap = (b == CharUpperG || b == CharLowerG);
            r.stat = (b == CharUpperS || b == CharLowerS);
            r.fs = parse_byte(b);
            r.last = 1'b1;
            expected_results.push_back(r);
        end
        else if (rptr == wptr)
        begin
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            cnt = (q_len[rptr] == 0) ? 1 : q_len[rptr];
            for (int k = 0; k < cnt; k++)
            begin
                r = '0;
                r.kind = KIND_FRAME;
                r.fs = FS_NONE;
                r.cmd = q_cmd[rptr];
                r.seq = q_seq[rptr];
                r.plen = q_len[rptr][5:0];
                if (q_len[rptr] != 0)
                begin
                    r.pbyte = q_pl[rptr][k];
                    r.pvalid = 1'b1;
                end
                r.last = (k + 1 == cnt);
                expected_results.push_back(r);
            end
            rptr = (rptr + 1) % QDEPTH;
            n_dequeued++;
        end
    endfunction

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    bit sender_gaps = 1'b1;

    // valid stays high into the next item when there is no gap
    task automatic send_item(logic f, logic [7:0] b);
        int g;
        g = sender_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.func <= f;
        rx_ch.rx_byte <= b;
        @(negedge clk);
        while (!rx_ch.ready) @(negedge clk);
        @(posedge clk);
        predict(f, b);
        n_items++;
    endtask

    task automatic send_frame(logic [7:0] v, logic [7:0] c, logic [7:0] s, int len,
                              bit corrupt);
        logic [15:0] crc;
        logic [7:0] d;
        crc = crc_step(crc_step(16'hFFFF, m0), m1);
        send_item(1'b0, m0);
        send_item(1'b0, m1);
        send_item(1'b0, v); crc = crc_step(crc, v);
        send_item(1'b0, c); crc = crc_step(crc, c);
        send_item(1'b0, s); crc = crc_step(crc, s);
        send_item(1'b0, len[7:0]); crc = crc_step(crc, len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom);
            send_item(1'b0, d);
            crc = crc_step(crc, d);
        end
        if (corrupt) crc = crc ^ 16'h0100;
        send_item(1'b0, crc[7:0]);
        send_item(1'b0, crc[15:8]);
    endtask

    task automatic wait_drain();
        rx_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4 * MAXPL + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CfgAddrW'(idx) << 2; pwdata <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegFirstMagic: m0 = val;
            RegSecondMagic: m1 = val;
            default: ver = val;
        endcase
    endtask

    // result receiver with random stalls; a hold-off request stalls it once before random stalls resume
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind = kind_t'(res_ch.result_kind);
            got.cap = res_ch.capture_request;
            got.stat = res_ch.status_request;
            got.fs = frame_status_t'(res_ch.frame_status);
            got.cmd = res_ch.command;
            got.seq = res_ch.sequence_res;
            got.plen = res_ch.payload_length;
            got.pbyte = res_ch.payload_byte;
            got.pvalid = res_ch.payload_valid;
            got.last = res_ch.last;
            n_results++;
            if (expected_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch at result %0d: expected %h actual %h",
                                 n_results, want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(1'b1, 8'h00);
        send_item(1'b0, CharUpperG);
        send_item(1'b0, CharLowerG);
        send_item(1'b0, CharUpperS);
        send_item(1'b0, CharLowerS);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, m0);
        send_item(1'b0, m0);
        send_frame(ver, 8'h00, 8'hFF, 0, 1'b0);
        send_frame(ver, 8'hFF, 8'h00, MAXPL, 1'b0);
        send_frame(ver, 8'h12, 8'h34, 3, 1'b1);
        send_frame(8'h7F, 8'h12, 8'h34, 1, 1'b0);
        send_item(1'b0, m0); send_item(1'b0, m1);
        send_item(1'b0, ver); send_item(1'b0, 8'h01); send_item(1'b0, 8'h02);
        send_item(1'b0, 8'(MAXPL + 1));
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        wait_drain();
    endtask

    task automatic test_queue_full();
        for (int i = 0; i < QDEPTH + 1; i++)
            send_frame(ver, 8'(i), 8'(i), $urandom_range(0, 3), 1'b0);
        hold_off = 1'b1;
        for (int i = 0; i < 4; i++) send_item(1'b1, 8'h00);
        for (int i = 0; i < QDEPTH; i++) send_item(1'b1, 8'($urandom));
        wait_drain();
    endtask

    task automatic test_random(int target);
        int p;
        while (n_items < target)
        begin
            p = $urandom_range(0, 99);
            if (p < 55)
                send_frame(($urandom_range(0, 9) == 0) ? 8'($urandom) : ver,
                           8'($urandom), 8'($urandom),
                           ($urandom_range(0, 9) == 0) ? MAXPL : $urandom_range(0, 6),
                           $urandom_range(0, 9) == 0);
            else if (p < 80)
                send_item(1'b1, 8'($urandom));
            else if (p < 85)
            begin
                send_item(1'b0, m0); send_item(1'b0, m1); send_item(1'b0, ver);
                send_item(1'b0, 8'($urandom)); send_item(1'b0, 8'($urandom));
                send_item(1'b0, 8'($urandom_range(MAXPL + 1, 255)));
            end
            else
                send_item(1'b0, 8'($urandom));
        end
        sender_gaps = 1'b0;
        wait_drain();
        sender_gaps = 1'b1;
    endtask

    task automatic test_config(logic [7:0] a, logic [7:0] b, logic [7:0] v);
        write_reg(RegFirstMagic, a);
        write_reg(RegSecondMagic, b);
        write_reg(RegVersion, v);
        send_frame(v, 8'h5A, 8'hA5, 2, 1'b0);
        send_item(1'b1, 8'h00);
        test_random(n_items + 15);
    endtask

    initial
    begin
        m0 = FirstMagicRst; m1 = SecondMagicRst; ver = VersionRst;
        parser_clear();
        wptr = 0; rptr = 0;
        n_items = 0; n_results = 0; n_mismatch = 0; idle_cycles = 0;
        n_frames_ok = 0; n_dequeued = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_queue_full();
        test_random(n_items + 20);
        test_config(8'h00, 8'hFF, 8'hFF);
        test_config(8'h7E, 8'h7E, 8'h00);
        test_config(8'hFF, 8'h00, 8'h80);
        test_config(FirstMagicRst, SecondMagicRst, VersionRst);
        $display("covered %0d items, %0d results, %0d frames queued, %0d dequeued",
                 n_items, n_results, n_frames_ok, n_dequeued);
        $display("magic, version and queue full/empty cases exercised; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
sv/fcr_pkg.sv
sv/fcr_if.sv
sv/fcr_ram.sv
sv/fcr_regs.sv
sv/fcr_datapath.sv
sv/fcr_ctrl.sv
sv/framed_command_receiver_top.sv
test/tb.sv
